[rtl/lfu_pkg.sv]
// shared types, constants and helpers of the lfu cache heap
// used by lfu_heap_store and lfu_cache_heap; no dependencies
package lfu_pkg;

  localparam int KEY_SPACE  = 1024;
  localparam int HEAP_DEPTH = 64;

  localparam int KEY_IN_W = 10;
  localparam int VALUE_W  = 31;
  localparam int COUNT_W  = 32;
  localparam int STAMP_W  = 48;
  localparam int CAP_W    = 7;
  localparam int CAP_RESET = 64;

  localparam int KEY_AW  = (KEY_SPACE > 1) ? $clog2(KEY_SPACE) : 1;
  localparam int HEAP_AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int OCC_W   = $clog2(HEAP_DEPTH + 1);
  localparam int IDX_W   = HEAP_AW + 2;

  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;

  typedef struct packed {
    logic [KEY_AW-1:0]  key;
    logic [COUNT_W-1:0] count;
    logic [STAMP_W-1:0] stamp;
  } heap_entry_t;

  typedef struct packed {
    logic               en;
    logic [HEAP_AW-1:0] addr;
    heap_entry_t        data;
  } heap_wr_t;

  // heap order: fewer uses first, then older stamp
  function automatic logic ranks_below(heap_entry_t a, heap_entry_t b);
    logic r;
    if (a.count == b.count) begin
      r = a.stamp < b.stamp;
    end else begin
      r = a.count < b.count;
    end
    return r;
  endfunction

  function automatic logic [KEY_AW-1:0] key_fold(logic [KEY_IN_W-1:0] k);
    logic [31:0] w;
    w = 32'(k) % KEY_SPACE;
    return w[KEY_AW-1:0];
  endfunction

endpackage

[rtl/lfu_heap_store.sv]
// heap slot memory: one write port, two registered read ports
// depends on lfu_pkg
module lfu_heap_store import lfu_pkg::*; (
  input  logic               clk_i,
  input  heap_wr_t           wr_i,
  input  logic [HEAP_AW-1:0] rd_a_addr_i,
  input  logic [HEAP_AW-1:0] rd_b_addr_i,
  output heap_entry_t        rd_a_o,
  output heap_entry_t        rd_b_o
);

  heap_entry_t mem_q [HEAP_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_a_o <= mem_q[rd_a_addr_i];
    rd_b_o <= mem_q[rd_b_addr_i];
  end

endmodule

[rtl/lfu_cache_heap.sv]
// least-frequently-used key/value cache with a min-heap eviction order
// depends on lfu_pkg and lfu_heap_store
//
// usage:
//  - input words on the s_axis channel: tuser is the kind (0 get, 1 put),
//    tdata carries key and value; one result word per input on m_axis
//    (found flag and read value)
//  - cache_capacity register at byte address 0 of the apb-style port (paddr
//    is not decoded, every address reaches it); the user must see that it is
//    written only while the block is idle, as the block does not enforce it
//  - one word at a time; a get miss or an ignored put goes from the lookup
//    to the result, a new key appended as a leaf is sifted up, a touch or
//    an eviction is sifted down, one heap level per read/compare pair of
//    the slot memory; the result becomes valid in the same cycle as the
//    block is ready for the next word
//  - after reset the present-flag memory is cleared one key per cycle, all
//    KEY_SPACE keys (1024), with s_axis_tready low; config still works
//  - the result sits in an output register; a new word is accepted while it
//    waits, and the next result holds in the engine until m_axis_tready
module lfu_cache_heap import lfu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [9:0] key, [40:10] value, [47:41] zero
  input  logic [47:0] s_axis_tdata_i,
  // [0] kind
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] found, [31:1] read_value
  output logic [31:0] m_axis_tdata_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_LOOK  = 4'd2;
  localparam logic [3:0] S_TOUCH = 4'd3;
  localparam logic [3:0] S_EVICT = 4'd4;
  localparam logic [3:0] S_DRD   = 4'd5;
  localparam logic [3:0] S_DCMP  = 4'd6;
  localparam logic [3:0] S_URD   = 4'd7;
  localparam logic [3:0] S_UCMP  = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  // register file
  logic [CAP_W-1:0] cap_q;
  logic             cfg_wr;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = {{(32-CAP_W){1'b0}}, cap_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_W'(CAP_RESET);
    end else if (cfg_wr) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  // effective capacity, clamped to the heap depth
  logic [31:0] cap_eff;
  assign cap_eff = (32'(cap_q) > HEAP_DEPTH) ? 32'(HEAP_DEPTH) : 32'(cap_q);

  // control and payload registers
  logic [3:0]         state_q, state_d;
  logic [KEY_AW-1:0]  clr_q, clr_d;
  logic               kind_q, kind_d;
  logic [KEY_AW-1:0]  key_q, key_d;
  logic [VALUE_W-1:0] val_q, val_d;
  logic [HEAP_AW-1:0] pos_q, pos_d;
  logic [HEAP_AW-1:0] p_q, p_d;
  heap_entry_t        ent_q, ent_d;
  logic [OCC_W-1:0]   occ_q, occ_d;
  logic [STAMP_W-1:0] stamp_q, stamp_d;
  logic               res_found_q, res_found_d;
  logic [VALUE_W-1:0] res_value_q, res_value_d;
  logic               out_valid_q, out_valid_d;
  logic [31:0]        out_data_q, out_data_d;

  // key-indexed memories: {present, value} and heap position
  logic [VALUE_W:0]   kv_mem_q [KEY_SPACE];
  logic [HEAP_AW-1:0] pos_mem_q [KEY_SPACE];
  logic [VALUE_W:0]   kv_rd_q;
  logic [HEAP_AW-1:0] pos_rd_q;
  logic [KEY_AW-1:0]  kv_raddr;
  logic               kv_we;
  logic [KEY_AW-1:0]  kv_waddr;
  logic [VALUE_W:0]   kv_wdata;
  logic               pos_we;
  logic [KEY_AW-1:0]  pos_waddr;
  logic [HEAP_AW-1:0] pos_wdata;

  always_ff @(posedge clk_i) begin
    if (kv_we) begin
      kv_mem_q[kv_waddr] <= kv_wdata;
    end
    if (pos_we) begin
      pos_mem_q[pos_waddr] <= pos_wdata;
    end
    kv_rd_q  <= kv_mem_q[kv_raddr];
    pos_rd_q <= pos_mem_q[kv_raddr];
  end

  // heap slots
  heap_wr_t           heap_wr;
  logic [HEAP_AW-1:0] rd_a_addr, rd_b_addr;
  heap_entry_t        rd_a, rd_b;

  lfu_heap_store u_heap (
    .clk_i       (clk_i),
    .wr_i        (heap_wr),
    .rd_a_addr_i (rd_a_addr),
    .rd_b_addr_i (rd_b_addr),
    .rd_a_o      (rd_a),
    .rd_b_o      (rd_b)
  );

  logic in_acc;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // child and parent slots of the current position
  logic [IDX_W-1:0] l_idx, r_idx, occ_x;
  logic [HEAP_AW-1:0] par_idx;
  assign l_idx   = IDX_W'({p_q, 1'b1});
  assign r_idx   = l_idx + IDX_W'(1);
  assign occ_x   = IDX_W'(occ_q);
  assign par_idx = HEAP_AW'((p_q - HEAP_AW'(1)) >> 1);

  logic        hit;
  logic        pos_ok;
  logic        l_wins, r_wins;
  heap_entry_t best;
  logic [COUNT_W-1:0] cnt_inc;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    kind_d      = kind_q;
    key_d       = key_q;
    val_d       = val_q;
    pos_d       = pos_q;
    p_d         = p_q;
    ent_d       = ent_q;
    occ_d       = occ_q;
    stamp_d     = stamp_q;
    res_found_d = res_found_q;
    res_value_d = res_value_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    kv_raddr  = key_fold(s_axis_tdata_i[KEY_IN_W-1:0]);
    kv_we     = 1'b0;
    kv_waddr  = key_q;
    kv_wdata  = {1'b1, val_q};
    pos_we    = 1'b0;
    pos_waddr = ent_q.key;
    pos_wdata = p_q;
    heap_wr.en   = 1'b0;
    heap_wr.addr = p_q;
    heap_wr.data = ent_q;
    rd_a_addr = l_idx[HEAP_AW-1:0];
    rd_b_addr = r_idx[HEAP_AW-1:0];

    hit     = kv_rd_q[VALUE_W];
    pos_ok  = (OCC_W'(pos_rd_q) < occ_q) && (32'(pos_rd_q) < HEAP_DEPTH);
    cnt_inc = (rd_a.count == '1) ? rd_a.count : rd_a.count + COUNT_W'(1);

    l_wins = (l_idx < occ_x) && ranks_below(rd_a, ent_q);
    best   = l_wins ? rd_a : ent_q;
    r_wins = (r_idx < occ_x) && ranks_below(rd_b, best);

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLR: begin
        kv_we    = 1'b1;
        kv_waddr = clr_q;
        kv_wdata = '0;
        clr_d    = clr_q + KEY_AW'(1);
        if (32'(clr_q) == KEY_SPACE - 1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          kind_d  = s_axis_tuser_i;
          key_d   = key_fold(s_axis_tdata_i[KEY_IN_W-1:0]);
          val_d   = s_axis_tdata_i[KEY_IN_W +: VALUE_W];
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        res_found_d = hit;
        res_value_d = (kind_q == KIND_GET && hit) ? kv_rd_q[VALUE_W-1:0] : '0;
        pos_d       = pos_rd_q;
        rd_a_addr   = hit ? pos_rd_q : '0;
        state_d     = S_FIN;
        if (kind_q == KIND_GET) begin
          if (hit && pos_ok) begin
            state_d = S_TOUCH;
          end
        end else if (cap_eff != 32'd0) begin
          kv_we = 1'b1;
          if (hit) begin
            if (pos_ok) begin
              state_d = S_TOUCH;
            end
          end else if (32'(occ_q) >= cap_eff) begin
            state_d = S_EVICT;
          end else begin
            // new leaf at the end, then sift up
            ent_d.key   = key_q;
            ent_d.count = COUNT_W'(1);
            ent_d.stamp = stamp_q;
            stamp_d     = stamp_q + STAMP_W'(1);
            p_d         = HEAP_AW'(occ_q);
            occ_d       = occ_q + OCC_W'(1);
            state_d     = S_URD;
          end
        end
      end
      S_TOUCH: begin
        ent_d.key   = rd_a.key;
        ent_d.count = cnt_inc;
        ent_d.stamp = stamp_q;
        stamp_d     = stamp_q + STAMP_W'(1);
        p_d         = pos_q;
        state_d     = S_DRD;
      end
      S_EVICT: begin
        // root is the victim; new key takes its slot
        kv_we       = 1'b1;
        kv_waddr    = rd_a.key;
        kv_wdata    = '0;
        ent_d.key   = key_q;
        ent_d.count = COUNT_W'(1);
        ent_d.stamp = stamp_q;
        stamp_d     = stamp_q + STAMP_W'(1);
        p_d         = '0;
        state_d     = S_DRD;
      end
      S_DRD: begin
        state_d = S_DCMP;
      end
      S_DCMP: begin
        heap_wr.en = 1'b1;
        pos_we     = 1'b1;
        if (r_wins) begin
          heap_wr.data = rd_b;
          pos_waddr    = rd_b.key;
          p_d          = r_idx[HEAP_AW-1:0];
          state_d      = S_DRD;
        end else if (l_wins) begin
          heap_wr.data = rd_a;
          pos_waddr    = rd_a.key;
          p_d          = l_idx[HEAP_AW-1:0];
          state_d      = S_DRD;
        end else begin
          state_d = S_FIN;
        end
      end
      S_URD: begin
        rd_a_addr = par_idx;
        if (p_q == '0) begin
          heap_wr.en = 1'b1;
          pos_we     = 1'b1;
          state_d    = S_FIN;
        end else begin
          state_d = S_UCMP;
        end
      end
      S_UCMP: begin
        heap_wr.en = 1'b1;
        pos_we     = 1'b1;
        if (ranks_below(ent_q, rd_a)) begin
          heap_wr.data = rd_a;
          pos_waddr    = rd_a.key;
          p_d          = par_idx;
          state_d      = S_URD;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        // hand the result over once the output register is free
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = {res_value_q, res_found_q};
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      occ_q       <= '0;
      stamp_q     <= STAMP_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      occ_q       <= occ_d;
      stamp_q     <= stamp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    key_q       <= key_d;
    val_q       <= val_d;
    pos_q       <= pos_d;
    p_q         <= p_d;
    ent_q       <= ent_d;
    res_found_q <= res_found_d;
    res_value_q <= res_value_d;
    out_data_q  <= out_data_d;
  end

endmodule
